@@ sv/qsfb_pkg.sv @@
package qsfb_pkg;

   // frame geometry and coordinate format
   localparam int FB_WIDTH        = 128;
   localparam int FB_HEIGHT       = 128;
   localparam int COORD_FRAC_BITS = 4;
   localparam int ONE_UNIT        = 1 << COORD_FRAC_BITS;

   // store
   localparam int ADDR_W      = 14;
   localparam int STORE_DEPTH = 1 << ADDR_W;
   localparam int PIX_W       = 32;
   localparam int CNT_W       = 16;

   // datapath widths
   localparam int CW   = 16;
   localparam int XB   = (FB_WIDTH > 1) ? $clog2(FB_WIDTH) : 1;
   localparam int YB   = (FB_HEIGHT > 1) ? $clog2(FB_HEIGHT) : 1;
   localparam int YCW  = YB + COORD_FRAC_BITS + 1;
   localparam int DYW  = ((YCW > CW) ? YCW : CW) + 1;
   localparam int NUMW = CW + 1 + DYW + 1;
   localparam int DENW = CW + COORD_FRAC_BITS;
   localparam int QB   = 17 - COORD_FRAC_BITS;
   localparam int XW   = 18;
   localparam int MAW  = YB + XB + ADDR_W;

   typedef enum logic [1:0] {
      CMD_DRAW  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [4:0] {
      OP_NOP, OP_LOAD, OP_CLR, OP_RD, OP_TRI, OP_SORT0, OP_SORT1, OP_SORT2,
      OP_SETUP, OP_SEL, OP_MUL1, OP_MUL2, OP_ADD, OP_DIVGO, OP_SAVE, OP_SPAN,
      OP_PRD, OP_PWR, OP_NEXTY, OP_RESULT
   } op_type;

   typedef struct packed {
      logic [1:0]          cmd;
      logic signed [CW-1:0] corner0_x;
      logic signed [CW-1:0] corner0_y;
      logic signed [CW-1:0] corner1_x;
      logic signed [CW-1:0] corner1_y;
      logic signed [CW-1:0] corner2_x;
      logic signed [CW-1:0] corner2_y;
      logic signed [CW-1:0] corner3_x;
      logic signed [CW-1:0] corner3_y;
      logic [PIX_W-1:0]    fill_color;
      logic                card_visible;
      logic [ADDR_W-1:0]   pixel_index;
   } req_word_type;

   typedef struct packed {
      logic [PIX_W-1:0] read_pixel;
      logic [CNT_W-1:0] pixels_blended;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      op_type op;
      logic   sel;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] cmd;
      logic       draw_en;
      logic       tri_skip;
      logic       span_empty;
      logic       x_last;
      logic       y_last;
      logic       clr_last;
      logic       div_done;
   } stat_type;

   // premultiplied over, per channel: min(255, s + round(d*(255-a)/255))
   function automatic logic [PIX_W-1:0] blend_px(input logic [PIX_W-1:0] dst,
                                                 input logic [PIX_W-1:0] src);
      logic [7:0]  inv;
      logic [15:0] p;
      logic [16:0] v;
      logic [16:0] t;
      logic [8:0]  s;
      logic [PIX_W-1:0] o;
      inv = 8'd255 - src[7:0];
      o = '0;
      for (int i = 0; i < 4; i++) begin
         p = dst[8*i +: 8] * inv;
         v = 17'(p) + 17'd127;
         // exact divide by 255 for 16-bit values
         t = (v + (v >> 8) + 17'd1) >> 8;
         s = 9'(src[8*i +: 8]) + t[8:0];
         o[8*i +: 8] = (s > 9'd255) ? 8'd255 : s[7:0];
      end
      return o;
   endfunction

endpackage

@@ sv/qsfb_ifs.sv @@
interface qsfb_req_if import qsfb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           cmd;
   logic signed [CW-1:0] corner0_x;
   logic signed [CW-1:0] corner0_y;
   logic signed [CW-1:0] corner1_x;
   logic signed [CW-1:0] corner1_y;
   logic signed [CW-1:0] corner2_x;
   logic signed [CW-1:0] corner2_y;
   logic signed [CW-1:0] corner3_x;
   logic signed [CW-1:0] corner3_y;
   logic [PIX_W-1:0]     fill_color;
   logic                 card_visible;
   logic [ADDR_W-1:0]    pixel_index;

   modport source (output valid, cmd, corner0_x, corner0_y, corner1_x, corner1_y,
                   corner2_x, corner2_y, corner3_x, corner3_y, fill_color,
                   card_visible, pixel_index, input ready);
   modport sink (input valid, cmd, corner0_x, corner0_y, corner1_x, corner1_y,
                 corner2_x, corner2_y, corner3_x, corner3_y, fill_color,
                 card_visible, pixel_index, output ready);
endinterface

interface qsfb_rsp_if import qsfb_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] read_pixel;
   logic [CNT_W-1:0] pixels_blended;

   modport source (output valid, read_pixel, pixels_blended, input ready);
   modport sink (input valid, read_pixel, pixels_blended, output ready);
endinterface

@@ sv/qsfb_div.sv @@
// Restoring divider, one quotient bit a cycle; floor and ceil of num/den, den > 0.
module qsfb_div import qsfb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [NUMW-1:0] num,
   input  logic [DENW-1:0]        den,
   output logic                   done,
   output logic signed [XW-1:0]   q_floor,
   output logic signed [XW-1:0]   q_ceil
);

   localparam int RW = NUMW + QB;
   localparam int KW = $clog2(QB + 1);

   logic          run_ff, run_in;
   logic [KW-1:0] cnt_ff, cnt_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [RW-1:0] dsh_ff, dsh_in;
   logic [QB-1:0] q_ff, q_in;
   logic          neg_ff, neg_in;
   logic [NUMW-1:0] mag;
   logic            nz;
   logic signed [XW-1:0] qs;

   assign mag  = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
   assign done = run_ff && (cnt_ff == KW'(QB - 1));

   // step logic
   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      q_in   = q_ff;
      neg_in = neg_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = RW'(mag);
         dsh_in = RW'(den) << (QB - 1);
         q_in   = '0;
         neg_in = num[NUMW-1];
      end else if (run_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            q_in   = {q_ff[QB-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[QB-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff + KW'(1);
         if (done) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
   end

   // sign fix-up of the magnitude quotient
   assign nz = (rem_ff != '0);
   assign qs = XW'($signed({1'b0, q_ff}));
   assign q_floor = neg_ff ? (-qs - XW'(nz)) : qs;
   assign q_ceil  = neg_ff ? -qs : (qs + XW'(nz));

endmodule

@@ sv/qsfb_datapath.sv @@
// Vertex setup, edge interpolation, span walk and frame store.
module qsfb_datapath import qsfb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  ctl_type      ctl,
   input  req_word_type req_word,
   output stat_type     stat,
   output rsp_word_type rsp_word
);

   // latched item
   logic [1:0]           cmd_ff;
   logic signed [CW-1:0] cx_ff [4];
   logic signed [CW-1:0] cy_ff [4];
   logic [PIX_W-1:0]     color_ff;
   logic                 vis_ff;
   logic [ADDR_W-1:0]    pidx_ff;

   // triangle and row state
   logic signed [CW-1:0] vx_ff [3];
   logic signed [CW-1:0] vy_ff [3];
   logic [YB-1:0]        y_ff, yl_ff;
   logic [XB-1:0]        x_ff, xe_ff;
   logic signed [CW-1:0] ax_ff, bx_ff, ay_ff;
   logic signed [CW:0]   seg_ff;
   logic                 flat_ff;
   logic signed [NUMW-1:0] prod_ff, acc_ff;
   logic [DENW-1:0]      den_ff;
   logic signed [XW-1:0] lc_ff, lf_ff, sc_ff, sf_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [ADDR_W-1:0]    clr_ff;
   logic [PIX_W-1:0]     rdata_ff;
   rsp_word_type         rsp_ff;

   logic [PIX_W-1:0] store_mem [STORE_DEPTH];

   logic signed [CW:0]    hs;
   logic signed [CW+1:0]  ya, yb, ya_c, yb_c;
   logic signed [YCW-1:0] yy;
   logic                  upper;
   logic signed [CW:0]    dxv;
   logic signed [DYW-1:0] dyv;
   logic signed [XW-1:0]  xa, xb, xa_c, xb_c;
   logic [ADDR_W-1:0]     pix_addr;
   logic                  div_go, div_done;
   logic signed [XW-1:0]  q_floor, q_ceil;
   logic                  mem_we, mem_re;
   logic [ADDR_W-1:0]     mem_wa, mem_ra;
   logic [PIX_W-1:0]      mem_wd;

   // triangle setup terms
   assign hs   = (CW+1)'(vy_ff[2]) - (CW+1)'(vy_ff[0]);
   assign ya   = ((CW+2)'(vy_ff[0]) + (CW+2)'(ONE_UNIT - 1)) >>> COORD_FRAC_BITS;
   assign yb   = (CW+2)'(vy_ff[2]) >>> COORD_FRAC_BITS;
   assign ya_c = (ya < 0) ? '0 : ya;
   assign yb_c = (yb > FB_HEIGHT - 1) ? (CW+2)'(FB_HEIGHT - 1) : yb;

   // row terms
   assign yy    = $signed(YCW'(y_ff)) <<< COORD_FRAC_BITS;
   assign upper = (DYW'(yy) < DYW'(vy_ff[1]));
   assign dxv   = (CW+1)'(bx_ff) - (CW+1)'(ax_ff);
   assign dyv   = DYW'(yy) - DYW'(ay_ff);

   // span bounds
   assign xa   = (lc_ff < sc_ff) ? lc_ff : sc_ff;
   assign xb   = (lf_ff > sf_ff) ? lf_ff : sf_ff;
   assign xa_c = (xa < 0) ? '0 : xa;
   assign xb_c = (xb > FB_WIDTH - 1) ? XW'(FB_WIDTH - 1) : xb;

   assign pix_addr = ADDR_W'(MAW'(y_ff) * MAW'(FB_WIDTH) + MAW'(x_ff));

   assign div_go = (ctl.op == OP_DIVGO);

   qsfb_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_go),
      .num     (acc_ff),
      .den     (den_ff),
      .done    (div_done),
      .q_floor (q_floor),
      .q_ceil  (q_ceil)
   );

   // status
   assign stat.cmd        = cmd_ff;
   assign stat.draw_en    = vis_ff && (color_ff[7:0] != 8'd0);
   assign stat.tri_skip   = (ya_c > yb_c) || (2 * hs < ONE_UNIT);
   assign stat.span_empty = (xa_c > xb_c);
   assign stat.x_last     = (x_ff == xe_ff);
   assign stat.y_last     = (y_ff == yl_ff);
   assign stat.clr_last   = (clr_ff == '1);
   assign stat.div_done   = div_done;

   assign rsp_word = rsp_ff;

   // store port control
   assign mem_we = (ctl.op == OP_CLR) || (ctl.op == OP_PWR);
   assign mem_wa = (ctl.op == OP_CLR) ? clr_ff : pix_addr;
   assign mem_wd = (ctl.op == OP_CLR) ? '0 : blend_px(rdata_ff, color_ff);
   assign mem_re = (ctl.op == OP_RD) || (ctl.op == OP_PRD);
   assign mem_ra = (ctl.op == OP_RD) ? pidx_ff : pix_addr;

   always_ff @(posedge clock) begin
      if (mem_we) store_mem[mem_wa] <= mem_wd;
      if (mem_re) rdata_ff <= store_mem[mem_ra];
   end

   // clear sweep address
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (ctl.op == OP_CLR) begin
         clr_ff <= clr_ff + ADDR_W'(1);
      end
   end

   // datapath operations
   always_ff @(posedge clock) begin
      case (ctl.op)
         OP_LOAD: begin
            cmd_ff   <= req_word.cmd;
            cx_ff[0] <= req_word.corner0_x;
            cy_ff[0] <= req_word.corner0_y;
            cx_ff[1] <= req_word.corner1_x;
            cy_ff[1] <= req_word.corner1_y;
            cx_ff[2] <= req_word.corner2_x;
            cy_ff[2] <= req_word.corner2_y;
            cx_ff[3] <= req_word.corner3_x;
            cy_ff[3] <= req_word.corner3_y;
            color_ff <= req_word.fill_color;
            vis_ff   <= req_word.card_visible;
            pidx_ff  <= req_word.pixel_index;
            cnt_ff   <= '0;
         end
         OP_TRI: begin
            vx_ff[0] <= cx_ff[0];
            vy_ff[0] <= cy_ff[0];
            vx_ff[1] <= ctl.sel ? cx_ff[2] : cx_ff[1];
            vy_ff[1] <= ctl.sel ? cy_ff[2] : cy_ff[1];
            vx_ff[2] <= ctl.sel ? cx_ff[3] : cx_ff[2];
            vy_ff[2] <= ctl.sel ? cy_ff[3] : cy_ff[2];
         end
         OP_SORT0, OP_SORT2: begin
            if (vy_ff[0] > vy_ff[1]) begin
               vx_ff[0] <= vx_ff[1];
               vy_ff[0] <= vy_ff[1];
               vx_ff[1] <= vx_ff[0];
               vy_ff[1] <= vy_ff[0];
            end
         end
         OP_SORT1: begin
            if (vy_ff[1] > vy_ff[2]) begin
               vx_ff[1] <= vx_ff[2];
               vy_ff[1] <= vy_ff[2];
               vx_ff[2] <= vx_ff[1];
               vy_ff[2] <= vy_ff[1];
            end
         end
         OP_SETUP: begin
            y_ff  <= ya_c[YB-1:0];
            yl_ff <= yb_c[YB-1:0];
         end
         OP_SEL: begin
            // long edge v0..v2, or the short edge that holds this row
            if (!ctl.sel) begin
               ax_ff   <= vx_ff[0];
               bx_ff   <= vx_ff[2];
               ay_ff   <= vy_ff[0];
               seg_ff  <= hs;
               flat_ff <= 1'b0;
            end else if (upper) begin
               ax_ff   <= vx_ff[0];
               bx_ff   <= vx_ff[1];
               ay_ff   <= vy_ff[0];
               seg_ff  <= (CW+1)'(vy_ff[1]) - (CW+1)'(vy_ff[0]);
               flat_ff <= !(2 * ((CW+1)'(vy_ff[1]) - (CW+1)'(vy_ff[0])) > ONE_UNIT);
            end else begin
               ax_ff   <= vx_ff[1];
               bx_ff   <= vx_ff[2];
               ay_ff   <= vy_ff[1];
               seg_ff  <= (CW+1)'(vy_ff[2]) - (CW+1)'(vy_ff[1]);
               flat_ff <= !(2 * ((CW+1)'(vy_ff[2]) - (CW+1)'(vy_ff[1])) > ONE_UNIT);
            end
         end
         OP_MUL1: prod_ff <= NUMW'(ax_ff * seg_ff);
         OP_MUL2: begin
            acc_ff  <= prod_ff;
            prod_ff <= NUMW'(dxv * dyv);
         end
         OP_ADD: begin
            if (flat_ff) begin
               acc_ff <= NUMW'(bx_ff);
               den_ff <= DENW'(ONE_UNIT);
            end else begin
               acc_ff <= acc_ff + prod_ff;
               den_ff <= DENW'(seg_ff) << COORD_FRAC_BITS;
            end
         end
         OP_SAVE: begin
            if (!ctl.sel) begin
               lc_ff <= q_ceil;
               lf_ff <= q_floor;
            end else begin
               sc_ff <= q_ceil;
               sf_ff <= q_floor;
            end
         end
         OP_SPAN: begin
            x_ff  <= xa_c[XB-1:0];
            xe_ff <= xb_c[XB-1:0];
         end
         OP_PWR: begin
            x_ff <= x_ff + XB'(1);
            if (cnt_ff != '1) cnt_ff <= cnt_ff + CNT_W'(1);
         end
         OP_NEXTY: y_ff <= y_ff + YB'(1);
         OP_RESULT: begin
            rsp_ff.read_pixel     <= (cmd_ff == CMD_READ) ? rdata_ff : '0;
            rsp_ff.pixels_blended <= cnt_ff;
         end
         default: ;
      endcase
   end

endmodule

@@ sv/qsfb_ctrl.sv @@
// Sequencer for clear, read and draw words.
module qsfb_ctrl import qsfb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output ctl_type  ctl
);

   typedef enum logic [22:0] {
      S_CLR_RST  = 23'h000001,
      S_IDLE     = 23'h000002,
      S_DECODE   = 23'h000004,
      S_CLR_CMD  = 23'h000008,
      S_RD_ISSUE = 23'h000010,
      S_TRI      = 23'h000020,
      S_SORT0    = 23'h000040,
      S_SORT1    = 23'h000080,
      S_SORT2    = 23'h000100,
      S_SETUP    = 23'h000200,
      S_SEL      = 23'h000400,
      S_MUL1     = 23'h000800,
      S_MUL2     = 23'h001000,
      S_ADD      = 23'h002000,
      S_DIVGO    = 23'h004000,
      S_DIVWAIT  = 23'h008000,
      S_SAVE     = 23'h010000,
      S_SPAN     = 23'h020000,
      S_PRD      = 23'h040000,
      S_PWR      = 23'h080000,
      S_NEXTY    = 23'h100000,
      S_TRIEND   = 23'h200000,
      S_DONE     = 23'h400000
   } state_type;

   state_type state_ff, state_in;
   logic      side_ff, side_in;
   logic      tri_ff, tri_in;
   logic      rv_ff, rv_in;
   logic      slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rv_ff;
   assign slot_free = !rv_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      side_in  = side_ff;
      tri_in   = tri_ff;
      rv_in    = rv_ff && !rsp_ready;
      ctl.op   = OP_NOP;
      ctl.sel  = side_ff;
      case (state_ff)
         S_CLR_RST: begin
            ctl.op = OP_CLR;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               ctl.op   = OP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.cmd)
               CMD_DRAW: begin
                  tri_in   = 1'b0;
                  state_in = stat.draw_en ? S_TRI : S_DONE;
               end
               CMD_READ:  state_in = S_RD_ISSUE;
               CMD_CLEAR: state_in = S_CLR_CMD;
               default:   state_in = S_DONE;
            endcase
         end
         S_CLR_CMD: begin
            ctl.op = OP_CLR;
            if (stat.clr_last) state_in = S_DONE;
         end
         S_RD_ISSUE: begin
            ctl.op   = OP_RD;
            state_in = S_DONE;
         end
         S_TRI: begin
            ctl.op   = OP_TRI;
            ctl.sel  = tri_ff;
            state_in = S_SORT0;
         end
         S_SORT0: begin
            ctl.op   = OP_SORT0;
            state_in = S_SORT1;
         end
         S_SORT1: begin
            ctl.op   = OP_SORT1;
            state_in = S_SORT2;
         end
         S_SORT2: begin
            ctl.op   = OP_SORT2;
            state_in = S_SETUP;
         end
         S_SETUP: begin
            ctl.op  = OP_SETUP;
            side_in = 1'b0;
            state_in = stat.tri_skip ? S_TRIEND : S_SEL;
         end
         S_SEL: begin
            ctl.op   = OP_SEL;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            ctl.op   = OP_MUL1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            ctl.op   = OP_MUL2;
            state_in = S_ADD;
         end
         S_ADD: begin
            ctl.op   = OP_ADD;
            state_in = S_DIVGO;
         end
         S_DIVGO: begin
            ctl.op   = OP_DIVGO;
            state_in = S_DIVWAIT;
         end
         S_DIVWAIT: begin
            if (stat.div_done) state_in = S_SAVE;
         end
         S_SAVE: begin
            // long edge first, then the short one
            ctl.op = OP_SAVE;
            if (!side_ff) begin
               side_in  = 1'b1;
               state_in = S_SEL;
            end else begin
               state_in = S_SPAN;
            end
         end
         S_SPAN: begin
            ctl.op   = OP_SPAN;
            state_in = stat.span_empty ? S_NEXTY : S_PRD;
         end
         S_PRD: begin
            ctl.op   = OP_PRD;
            state_in = S_PWR;
         end
         S_PWR: begin
            ctl.op   = OP_PWR;
            state_in = stat.x_last ? S_NEXTY : S_PRD;
         end
         S_NEXTY: begin
            ctl.op  = OP_NEXTY;
            side_in = 1'b0;
            state_in = stat.y_last ? S_TRIEND : S_SEL;
         end
         S_TRIEND: begin
            if (!tri_ff) begin
               tri_in   = 1'b1;
               state_in = S_TRI;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               ctl.op   = OP_RESULT;
               rv_in    = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLR_RST;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR_RST;
         side_ff  <= 1'b0;
         tri_ff   <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         side_ff  <= side_in;
         tri_ff   <= tri_in;
         rv_ff    <= rv_in;
      end
   end

endmodule

@@ sv/quad_scanline_fill_blend.sv @@
// Draw: each of the two triangles is sorted and set up; each covered row then solves its long
//   and short edges with the bit-serial edge divider (QB = 13), and each pixel is read, then written.
// One word in flight; the next is taken while the result waits in its register.
// Reset: synchronous; afterward a sweep zeroes the store, no words taken.
module quad_scanline_fill_blend import qsfb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   qsfb_req_if.sink   req_chan,
   qsfb_rsp_if.source rsp_chan
);

   req_word_type req_word;
   rsp_word_type rsp_word;
   ctl_type      ctl;
   stat_type     stat;

   // gather the request payload
   assign req_word.cmd          = req_chan.cmd;
   assign req_word.corner0_x    = req_chan.corner0_x;
   assign req_word.corner0_y    = req_chan.corner0_y;
   assign req_word.corner1_x    = req_chan.corner1_x;
   assign req_word.corner1_y    = req_chan.corner1_y;
   assign req_word.corner2_x    = req_chan.corner2_x;
   assign req_word.corner2_y    = req_chan.corner2_y;
   assign req_word.corner3_x    = req_chan.corner3_x;
   assign req_word.corner3_y    = req_chan.corner3_y;
   assign req_word.fill_color   = req_chan.fill_color;
   assign req_word.card_visible = req_chan.card_visible;
   assign req_word.pixel_index  = req_chan.pixel_index;

   assign rsp_chan.read_pixel     = rsp_word.read_pixel;
   assign rsp_chan.pixels_blended = rsp_word.pixels_blended;

   qsfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   qsfb_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .req_word (req_word),
      .stat     (stat),
      .rsp_word (rsp_word)
   );

endmodule

@@ sv/qsfb_checker.sv @@
module qsfb_checker import qsfb_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [PIX_W-1:0] read_pixel,
   input logic [CNT_W-1:0] pixels_blended
);

   // a held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // a held result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(read_pixel) && $stable(pixels_blended))
      else $error("result payload changed while stalled");

   // one word at a time
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word taken while busy");

   // store sweep after reset takes no words
   a_reset_sweep: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("word taken during reset sweep");

   // a draw count and a pixel never come together
   a_result_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (read_pixel == '0) || (pixels_blended == '0))
      else $error("result carries both pixel and count");

endmodule

bind quad_scanline_fill_blend qsfb_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .read_pixel     (rsp_chan.read_pixel),
   .pixels_blended (rsp_chan.pixels_blended)
);
